### rtl/c8fb_pkg.sv
package c8fb_pkg;

    localparam int MAX_PAYLOAD = 28;
    localparam int BL_W        = $clog2(MAX_PAYLOAD + 1);
    localparam int QDEPTH      = 4;
    localparam int QAW         = $clog2(QDEPTH);
    localparam int QCW         = $clog2(QDEPTH + 1);

    localparam logic [7:0] CRC_POLY_REF   = 8'h8C;
    localparam logic [7:0] START_MARK_RST = 8'hAA;
    localparam logic [7:0] END_MARK_RST   = 8'hAD;

    localparam logic       CMD_START = 1'b0;
    localparam logic       CMD_DATA  = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_TOO_LONG = 2'd1;
    localparam logic [1:0] ST_NO_FRAME = 2'd2;

    localparam logic       REG_START_MARKER = 1'b0;
    localparam logic       REG_END_MARKER   = 1'b1;

    typedef enum logic [1:0] {
        K_ERR_LEN   = 2'd0,
        K_ERR_NOFRM = 2'd1,
        K_START     = 2'd2,
        K_DATA      = 2'd3
    } t_kind;

    // start: a/b = length hi/lo, last = empty frame
    // data:  a = payload byte, b = crc after it, last = closes frame
    typedef struct packed {
        t_kind      kind;
        logic       last;
        logic [7:0] a;
        logic [7:0] b;
    } t_job;

    function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_REF;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    function automatic logic [2:0] job_last_idx(input t_job j);
        logic [2:0] r;
        case (j.kind)
            K_START: r = j.last ? 3'd4 : 3'd2;
            K_DATA:  r = j.last ? 3'd2 : 3'd0;
            default: r = 3'd0;
        endcase
        return r;
    endfunction

endpackage

### rtl/c8fb_front.sv
module c8fb_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_command,
    input  logic [15:0]          i_frame_length,
    input  logic [7:0]           i_data_byte,
    output c8fb_pkg::t_job       o_job
);
    import c8fb_pkg::*;

    logic            r_open, n_open;
    logic [BL_W-1:0] r_left, n_left;
    logic [7:0]      r_crc, n_crc;

    always_comb begin
        n_open = r_open;
        n_left = r_left;
        n_crc  = r_crc;
        o_job  = '{kind: K_ERR_NOFRM, last: 1'b0, a: 8'h00, b: 8'h00};
        if (i_command == CMD_START) begin
            n_open = 1'b0;
            n_left = '0;
            if (i_frame_length > 16'(MAX_PAYLOAD)) begin
                o_job.kind = K_ERR_LEN;
            end else begin
                n_crc      = 8'h00;
                o_job.kind = K_START;
                o_job.a    = i_frame_length[15:8];
                o_job.b    = i_frame_length[7:0];
                o_job.last = (i_frame_length == 16'd0);
                if (i_frame_length != 16'd0) begin
                    n_left = i_frame_length[BL_W-1:0];
                    n_open = 1'b1;
                end
            end
        end else if (r_open) begin
            n_crc      = crc_fold(r_crc, i_data_byte);
            n_left     = (r_left != '0) ? r_left - 1'b1 : r_left;
            o_job.kind = K_DATA;
            o_job.a    = i_data_byte;
            o_job.b    = n_crc;
            o_job.last = (n_left == '0);
            if (n_left == '0) begin
                n_open = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_left <= '0;
            r_crc  <= 8'h00;
        end else if (i_accept) begin
            r_open <= n_open;
            r_left <= n_left;
            r_crc  <= n_crc;
        end
    end

endmodule

### rtl/c8fb_fifo.sv
module c8fb_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  c8fb_pkg::t_job  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output c8fb_pkg::t_job  o_data
);
    import c8fb_pkg::*;

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QCW-1:0] r_cnt;

    assign o_full  = (r_cnt == QCW'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == QAW'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == QAW'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### rtl/c8fb_back.sv
module c8fb_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  c8fb_pkg::t_job  i_job,
    output logic            o_pop,
    input  logic [7:0]      i_start_marker,
    input  logic [7:0]      i_end_marker,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_frame_end,
    output logic [1:0]      o_status
);
    import c8fb_pkg::*;

    logic       r_vld;
    logic [2:0] r_idx;
    logic [7:0] r_byte, n_byte;
    logic       r_end, n_end;
    logic [1:0] r_st, n_st;
    logic       w_load, w_lastb;

    assign w_load  = !i_empty && (!r_vld || i_out_ready);
    assign w_lastb = (r_idx == job_last_idx(i_job));
    assign o_pop   = w_load && w_lastb;

    always_comb begin
        n_byte = 8'h00;
        n_end  = 1'b0;
        n_st   = ST_OK;
        case (i_job.kind)
            K_ERR_LEN:   n_st = ST_TOO_LONG;
            K_ERR_NOFRM: n_st = ST_NO_FRAME;
            K_START: begin
                case (r_idx)
                    3'd0:    n_byte = i_start_marker;
                    3'd1:    n_byte = i_job.a;
                    3'd2:    n_byte = i_job.b;
                    3'd3:    n_byte = 8'h00;
                    default: begin
                        n_byte = i_end_marker;
                        n_end  = 1'b1;
                    end
                endcase
            end
            default: begin
                case (r_idx)
                    3'd0:    n_byte = i_job.a;
                    3'd1:    n_byte = i_job.b;
                    default: begin
                        n_byte = i_end_marker;
                        n_end  = 1'b1;
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_idx <= '0;
        end else begin
            if (w_load) begin
                r_vld <= 1'b1;
                r_idx <= w_lastb ? 3'd0 : r_idx + 1'b1;
            end else if (i_out_ready) begin
                r_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= n_byte;
            r_end  <= n_end;
            r_st   <= n_st;
        end
    end

    assign o_out_valid = r_vld;
    assign o_out_byte  = r_byte;
    assign o_frame_end = r_end;
    assign o_status    = r_st;

endmodule

### rtl/crc8_byte_frame_builder.sv
// channel  dir  handshake                 payload
// in       in   i_in_valid / o_in_ready   i_command, i_frame_length, i_data_byte
// out      out  o_out_valid / i_out_ready o_out_byte, o_frame_end, o_status
// cfg      in   psel/penable/pwrite       paddr, pwdata, prdata, pready
//
// One item is taken per cycle while the 4-entry job queue has room.
// The back end sends one byte per cycle unless the output stalls or the queue is empty:
// an item yields 1, 3 or 5 bytes, so sustained rate is set by the output serializer.
// Items pass the job queue, then the output register. Synchronous active-low reset.
// Output stall backs up the queue; input stalls only when the queue is full.
module crc8_byte_frame_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_command,
    input  logic [15:0] i_frame_length,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_frame_end,
    output logic [1:0]  o_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import c8fb_pkg::*;

    logic [7:0] r_smark, r_emark;
    t_job       w_job_in, w_job_out;
    logic       w_full, w_empty, w_pop, w_accept;

    assign pready     = 1'b1;
    assign o_in_ready = !w_full;
    assign w_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smark <= START_MARK_RST;
            r_emark <= END_MARK_RST;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[2] == REG_START_MARKER) begin
                r_smark <= pwdata[7:0];
            end else begin
                r_emark <= pwdata[7:0];
            end
        end
    end

    assign prdata = {24'h0, (paddr[2] == REG_END_MARKER) ? r_emark : r_smark};

    c8fb_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_command      (i_command),
        .i_frame_length (i_frame_length),
        .i_data_byte    (i_data_byte),
        .o_job          (w_job_in)
    );

    c8fb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_data  (w_job_out)
    );

    c8fb_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (w_empty),
        .i_job          (w_job_out),
        .o_pop          (w_pop),
        .i_start_marker (r_smark),
        .i_end_marker   (r_emark),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_frame_end    (o_frame_end),
        .o_status       (o_status)
    );

`ifndef ASSERT_OFF
    a_end_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_end) |-> (o_status == ST_OK))
        else $error("frame end with error status");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_out_byte == 8'h00 && !o_frame_end))
        else $error("error result carries data");
    a_rst_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (!o_out_valid && o_in_ready))
        else $error("not idle after reset");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("queue pop while empty");
`endif

endmodule

### tb/sv/c8fb_frame_checker.sv
`timescale 1ns / 100ps

module c8fb_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_command,
    input  logic [15:0] i_frame_length,
    input  logic [7:0]  i_data_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [7:0]  i_out_byte,
    input  logic        i_frame_end,
    input  logic [1:0]  i_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_bytes_due
);
    import c8fb_pkg::*;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic [1:0] status;
    } t_frame_byte;

    t_frame_byte frame_bytes_due[$];

    logic [7:0] start_mark = START_MARK_RST;
    logic [7:0] end_mark   = END_MARK_RST;
    logic [7:0] crc_acc    = '0;
    logic [4:0] payload_left = '0;
    logic       in_frame   = 1'b0;
    int         fails      = 0;

    function automatic logic [7:0] crc8_maxim_fold(input logic [7:0] crc, input logic [7:0] d);
        logic [7:0] c;
        c = crc ^ d;
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY_REF) : (c >> 1);
        end
        return c;
    endfunction

    task automatic expect_byte(input logic [7:0] b, input logic e, input logic [1:0] s);
        frame_bytes_due.push_back({b, e, s});
    endtask

    task automatic predict_frame_bytes(input logic cmd, input logic [15:0] len,
                                       input logic [7:0] d);
        if (cmd == CMD_START) begin
            in_frame     = 1'b0;
            payload_left = '0;
            if (len > MAX_PAYLOAD) begin
                expect_byte(8'h00, 1'b0, ST_TOO_LONG);
            end else begin
                crc_acc = '0;
                expect_byte(start_mark, 1'b0, ST_OK);
                expect_byte(len[15:8], 1'b0, ST_OK);
                expect_byte(len[7:0], 1'b0, ST_OK);
                if (len == 16'd0) begin
                    expect_byte(crc_acc, 1'b0, ST_OK);
                    expect_byte(end_mark, 1'b1, ST_OK);
                end else begin
                    payload_left = len[4:0];
                    in_frame     = 1'b1;
                end
            end
        end else if (!in_frame) begin
            expect_byte(8'h00, 1'b0, ST_NO_FRAME);
        end else begin
            expect_byte(d, 1'b0, ST_OK);
            crc_acc = crc8_maxim_fold(crc_acc, d);
            if (payload_left != 0) begin
                payload_left = payload_left - 1'b1;
            end
            if (payload_left == 0) begin
                expect_byte(crc_acc, 1'b0, ST_OK);
                expect_byte(end_mark, 1'b1, ST_OK);
                in_frame = 1'b0;
            end
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_frame_byte want;
        if (!i_rst_n) begin
            start_mark   = START_MARK_RST;
            end_mark     = END_MARK_RST;
            crc_acc      = '0;
            payload_left = '0;
            in_frame     = 1'b0;
            frame_bytes_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == {REG_START_MARKER, 2'b00}) begin
                    start_mark = pwdata[7:0];
                end else if (paddr == {REG_END_MARKER, 2'b00}) begin
                    end_mark = pwdata[7:0];
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_frame_bytes(i_command, i_frame_length, i_data_byte);
            end
            if (i_out_valid && i_out_ready) begin
                if (frame_bytes_due.size() == 0) begin
                    $error("unexpected output item: out_byte %0h frame_end %0b status %0d",
                           i_out_byte, i_frame_end, i_status);
                    fails++;
                end else begin
                    want = frame_bytes_due.pop_front();
                    if (i_out_byte !== want.out_byte) begin
                        $error("out_byte: expected %0h, got %0h", want.out_byte, i_out_byte);
                        fails++;
                    end
                    if (i_frame_end !== want.frame_end) begin
                        $error("frame_end: expected %0b, got %0b", want.frame_end, i_frame_end);
                        fails++;
                    end
                    if (i_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, i_status);
                        fails++;
                    end
                end
            end
        end
        o_bytes_due  <= frame_bytes_due.size();
        o_fail_count <= fails;
    end

endmodule

### tb/sv/crc8_byte_frame_builder_test.sv
`timescale 1ns / 100ps

module crc8_byte_frame_builder_test;
    import c8fb_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_command;
    logic [15:0] i_frame_length;
    logic [7:0]  i_data_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_out_byte;
    logic        o_frame_end;
    logic [1:0]  o_status;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int bytes_due;
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int items_sent   = 0;
    int stall_cycles = 0;

    crc8_byte_frame_builder DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_frame_length (i_frame_length),
        .i_data_byte    (i_data_byte),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_frame_end    (o_frame_end),
        .o_status       (o_status),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    c8fb_frame_checker frame_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_frame_length (i_frame_length),
        .i_data_byte    (i_data_byte),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_out_byte     (o_out_byte),
        .i_frame_end    (o_frame_end),
        .i_status       (o_status),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .o_fail_count   (fail_count),
        .o_bytes_due    (bytes_due)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rcv_idle_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_cycles <= 0;
        end else if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                     || (psel && penable && pwrite && pready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("crc8_byte_frame_builder_test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input logic cmd, input logic [15:0] len, input logic [7:0] d);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_command      <= cmd;
        i_frame_length <= len;
        i_data_byte    <= d;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {24'h0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (bytes_due != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic reconfigure(input logic [7:0] smark, input logic [7:0] emark);
        wait_drained();
        write_reg({REG_START_MARKER, 2'b00}, smark);
        write_reg({REG_END_MARKER, 2'b00}, emark);
    endtask

    // mostly well-formed frames, some cut short, plus stray bytes and oversize starts
    task automatic random_traffic(input int n_items);
        int stop_at;
        int pick;
        int len;
        int cut;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                send_item(CMD_DATA, 16'($urandom), 8'($urandom));
            end else if (pick < 14) begin
                len = $urandom_range(1) ? $urandom_range(65535, MAX_PAYLOAD + 1)
                                        : $urandom_range(MAX_PAYLOAD + 4, MAX_PAYLOAD + 1);
                send_item(CMD_START, 16'(len), 8'($urandom));
            end else begin
                pick = $urandom_range(99);
                if (pick < 10) begin
                    len = 0;
                end else if (pick < 20) begin
                    len = MAX_PAYLOAD;
                end else if (pick < 70) begin
                    len = $urandom_range(4, 1);
                end else begin
                    len = $urandom_range(MAX_PAYLOAD, 1);
                end
                cut = len;
                if (len > 1 && $urandom_range(99) < 10) begin
                    cut = $urandom_range(len - 1, 1);
                end
                send_item(CMD_START, 16'(len), 8'($urandom));
                repeat (cut) begin
                    send_item(CMD_DATA, 16'($urandom), 8'($urandom));
                end
            end
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_command      = CMD_START;
        i_frame_length = '0;
        i_data_byte    = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        snd_idle_pct = 23;
        rcv_idle_pct = 85;
        send_item(CMD_DATA, 16'h0000, 8'h5A);
        send_item(CMD_START, 16'd0, 8'hFF);
        send_item(CMD_START, 16'(MAX_PAYLOAD + 1), 8'h00);
        send_item(CMD_START, 16'hFFFF, 8'h00);
        send_item(CMD_START, 16'h0100, 8'h00);
        send_item(CMD_START, 16'd3, 8'h00);
        send_item(CMD_DATA, 16'hFFFF, 8'h00);
        send_item(CMD_DATA, 16'h0000, 8'hFF);
        send_item(CMD_DATA, 16'h0000, 8'h80);
        send_item(CMD_START, 16'd5, 8'h00);
        send_item(CMD_DATA, 16'h0000, 8'h12);
        send_item(CMD_START, 16'd1, 8'h00);
        send_item(CMD_DATA, 16'h0000, 8'hA5);
        send_item(CMD_START, 16'(MAX_PAYLOAD), 8'h00);
        send_item(CMD_START, 16'd2, 8'h00);
        send_item(CMD_DATA, 16'h0000, 8'h3C);
        send_item(CMD_DATA, 16'h0000, 8'hC3);
        send_item(CMD_DATA, 16'h0000, 8'h7E);
        send_item(CMD_START, 16'd4, 8'h00);
        send_item(CMD_START, 16'(MAX_PAYLOAD + 2), 8'h00);
        send_item(CMD_DATA, 16'h0000, 8'h01);
        random_traffic(110);

        reconfigure(8'h00, 8'hFF);
        snd_idle_pct = 85;
        rcv_idle_pct = 23;
        random_traffic(110);

        reconfigure(8'hFF, 8'h00);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        random_traffic(100);

        reconfigure(8'($urandom_range(255)), 8'($urandom_range(255)));
        random_traffic(100);

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && bytes_due == 0) begin
            $display("crc8_byte_frame_builder_test passed");
        end else begin
            $display("crc8_byte_frame_builder_test failed");
        end
        $finish;
    end

endmodule
